// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mplf_pkg.sv -----
// Types, codes and helpers for the mesh peer link state machine.
`default_nettype none
package mplf_pkg;

    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    // command codes
    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_BEACON = 1'b1;

    // received frame kinds
    localparam logic [1:0] FK_OPEN    = 2'd0;
    localparam logic [1:0] FK_CONFIRM = 2'd1;
    localparam logic [1:0] FK_CLOSE   = 2'd2;
    localparam logic [1:0] FK_OTHER   = 2'd3;

    // sent frame kinds
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_OPEN    = 2'd1;
    localparam logic [1:0] SEND_CONFIRM = 2'd2;
    localparam logic [1:0] SEND_CLOSE   = 2'd3;

    // timer commands
    localparam logic [1:0] TM_LEAVE = 2'd0;
    localparam logic [1:0] TM_START = 2'd1;
    localparam logic [1:0] TM_STOP  = 2'd2;

    // close reasons
    localparam logic [1:0] RSN_NONE     = 2'd0;
    localparam logic [1:0] RSN_CLOSE    = 2'd1;
    localparam logic [1:0] RSN_MISMATCH = 2'd2;

    // link state codes as reported
    localparam logic [2:0] LS_LISTEN   = 3'd0;
    localparam logic [2:0] LS_OPN_SNT  = 3'd1;
    localparam logic [2:0] LS_OPN_RCVD = 3'd2;
    localparam logic [2:0] LS_CNF_RCVD = 3'd3;
    localparam logic [2:0] LS_ESTAB    = 3'd4;
    localparam logic [2:0] LS_HOLDING  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_LINKS = 2'd0;
    localparam logic [1:0] REG_RETRY     = 2'd1;
    localparam logic [1:0] REG_CONFIRM   = 2'd2;
    localparam logic [1:0] REG_HOLDING   = 2'd3;

    localparam logic [7:0]  MAX_LINKS_RST = 8'd99;
    localparam logic [15:0] TIMEOUT_RST   = 16'd100;

    typedef enum logic [5:0] {
        ST_LISTEN   = 6'b000001,
        ST_OPN_SNT  = 6'b000010,
        ST_OPN_RCVD = 6'b000100,
        ST_CNF_RCVD = 6'b001000,
        ST_ESTAB    = 6'b010000,
        ST_HOLDING  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        EV_NONE, EV_OPN_ACPT, EV_OPN_RJCT, EV_OPN_IGNR, EV_CNF_ACPT,
        EV_CNF_RJCT, EV_CNF_IGNR, EV_CLS_ACPT, EV_CLS_IGNR
    } event_t;

    typedef struct packed {
        logic        command;
        logic [1:0]  frame_kind;
        logic        dest_multicast;
        logic [15:0] frame_sender_id;
        logic [15:0] frame_receiver_id;
        logic        profile_match;
        logic [7:0]  links_in_use;
        logic [15:0] fresh_local_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_local_id;
        logic [15:0] send_peer_id;
        logic [1:0]  timer_action;
        logic [15:0] timer_value_ms;
        logic [2:0]  link_state;
        logic        peer_present;
        logic [1:0]  close_reason;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  max_peer_links;
        logic [15:0] retry_timeout_ms;
        logic [15:0] confirm_timeout_ms;
        logic [15:0] holding_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        present;
        state_t      ls;
        logic [15:0] local_id;
        logic [15:0] peer_id;
        logic [1:0]  close_reason;
    } link_t;

    function automatic logic [2:0] state_code(state_t s);
        logic [2:0] c;
        unique case (s)
            ST_LISTEN:   c = LS_LISTEN;
            ST_OPN_SNT:  c = LS_OPN_SNT;
            ST_OPN_RCVD: c = LS_OPN_RCVD;
            ST_CNF_RCVD: c = LS_CNF_RCVD;
            ST_ESTAB:    c = LS_ESTAB;
            ST_HOLDING:  c = LS_HOLDING;
            default:     c = LS_LISTEN;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- src/mplf_core.sv -----
// Event classification and link state transition for one received word.
`default_nettype none
module mplf_core (
    input  mplf_pkg::in_word_t  in_word,
    input  mplf_pkg::cfg_t      cfg,
    input  mplf_pkg::link_t     cur,
    output mplf_pkg::link_t     nxt,
    output mplf_pkg::out_word_t res0,
    output mplf_pkg::out_word_t res1,
    output logic                two
);
    import mplf_pkg::*;

    event_t      ev;
    state_t      s_eff;
    logic        is_free;
    logic        prof_ok;
    logic        pid_bad;
    logic        reject;
    logic        to_hold;
    logic        is_beacon;
    logic        unknown_close;
    logic [1:0]  send;
    logic [1:0]  tact;
    logic [15:0] tval;
    logic [15:0] o_lid;
    logic [15:0] o_pid;
    logic [1:0]  o_rsn;
    logic [2:0]  o_ls;

    always_comb begin
        nxt           = cur;
        ev            = EV_NONE;
        send          = SEND_NONE;
        tact          = TM_LEAVE;
        tval          = '0;
        two           = 1'b0;
        to_hold       = 1'b0;
        is_beacon     = 1'b0;
        unknown_close = 1'b0;
        is_free = in_word.links_in_use < cfg.max_peer_links;
        prof_ok = (in_word.frame_kind == FK_CLOSE) || in_word.profile_match;
        pid_bad = (cur.peer_id != '0) && (cur.peer_id != in_word.frame_sender_id);

        if (in_word.command == CMD_BEACON) begin
            is_beacon   = 1'b1;
            nxt.present = 1'b1;
            if (cur.ls == ST_LISTEN) begin
                nxt.local_id = in_word.fresh_local_id;
                nxt.ls       = ST_OPN_SNT;
                send         = SEND_OPEN;
                tact         = TM_START;
                tval         = cfg.retry_timeout_ms;
            end
        end else if (in_word.dest_multicast || in_word.frame_kind == FK_OTHER) begin
            ev = EV_NONE;
        end else if (!cur.present) begin
            if (!prof_ok) begin
                unknown_close = 1'b1;
                send          = SEND_CLOSE;
            end else if (in_word.frame_kind == FK_OPEN && is_free) begin
                nxt.present      = 1'b1;
                nxt.ls           = ST_LISTEN;
                nxt.close_reason = RSN_NONE;
                nxt.peer_id      = '0;
                nxt.local_id     = '0;
                ev               = EV_OPN_ACPT;
            end
        end else if (in_word.frame_kind == FK_OPEN) begin
            priority if (!prof_ok)            ev = EV_OPN_RJCT;
            else if (!is_free || pid_bad)     ev = EV_OPN_IGNR;
            else                              ev = EV_OPN_ACPT;
        end else if (in_word.frame_kind == FK_CONFIRM) begin
            priority if (!prof_ok) ev = EV_CNF_RJCT;
            else if (!is_free || cur.local_id != in_word.frame_receiver_id || pid_bad)
                ev = EV_CNF_IGNR;
            else ev = EV_CNF_ACPT;
        end else begin
            priority if (cur.ls == ST_ESTAB) ev = EV_CLS_ACPT;
            else if (cur.peer_id != in_word.frame_sender_id) ev = EV_CLS_IGNR;
            else if (cur.local_id != '0 && cur.local_id != in_word.frame_receiver_id)
                ev = EV_CLS_IGNR;
            else ev = EV_CLS_ACPT;
        end

        if (ev == EV_OPN_ACPT) nxt.peer_id = in_word.frame_sender_id;
        if (ev == EV_CNF_ACPT && nxt.peer_id == '0) nxt.peer_id = in_word.frame_sender_id;

        reject = (ev == EV_OPN_RJCT) || (ev == EV_CNF_RJCT);
        s_eff  = nxt.ls;
        unique case (s_eff)
            ST_LISTEN: begin
                if (ev == EV_CLS_ACPT) begin
                    nxt.ls           = ST_LISTEN;
                    nxt.close_reason = RSN_NONE;
                    nxt.peer_id      = '0;
                    nxt.local_id     = '0;
                end else if (ev == EV_OPN_ACPT) begin
                    nxt.ls       = ST_OPN_RCVD;
                    nxt.local_id = in_word.fresh_local_id;
                    tact         = TM_START;
                    tval         = cfg.retry_timeout_ms;
                    send         = SEND_OPEN;
                    two          = 1'b1;
                end
            end
            ST_OPN_SNT: begin
                if (reject || ev == EV_CLS_ACPT) to_hold = 1'b1;
                else if (ev == EV_OPN_ACPT) begin
                    nxt.ls = ST_OPN_RCVD;
                    send   = SEND_CONFIRM;
                end else if (ev == EV_CNF_ACPT) begin
                    nxt.ls = ST_CNF_RCVD;
                    tact   = TM_START;
                    tval   = cfg.confirm_timeout_ms;
                end
            end
            ST_OPN_RCVD: begin
                if (reject || ev == EV_CLS_ACPT) to_hold = 1'b1;
                else if (ev == EV_OPN_ACPT) send = SEND_CONFIRM;
                else if (ev == EV_CNF_ACPT) begin
                    tact   = TM_STOP;
                    nxt.ls = ST_ESTAB;
                end
            end
            ST_CNF_RCVD: begin
                if (reject || ev == EV_CLS_ACPT) to_hold = 1'b1;
                else if (ev == EV_OPN_ACPT) begin
                    tact   = TM_STOP;
                    nxt.ls = ST_ESTAB;
                    send   = SEND_CONFIRM;
                end
            end
            ST_ESTAB: begin
                if (ev == EV_CLS_ACPT) to_hold = 1'b1;
                else if (ev == EV_OPN_ACPT) send = SEND_CONFIRM;
            end
            ST_HOLDING: begin
                if (ev == EV_CLS_ACPT) begin
                    tact             = TM_STOP;
                    nxt.ls           = ST_LISTEN;
                    nxt.close_reason = RSN_NONE;
                    nxt.peer_id      = '0;
                    nxt.local_id     = '0;
                end else if (ev == EV_OPN_ACPT || ev == EV_CNF_ACPT || reject) begin
                    send = SEND_CLOSE;
                end
            end
            default: begin
            end
        endcase

        if (to_hold) begin
            nxt.ls           = ST_HOLDING;
            nxt.close_reason = (ev == EV_CLS_ACPT) ? RSN_CLOSE : RSN_MISMATCH;
            tact             = TM_START;
            tval             = cfg.holding_timeout_ms;
            send             = SEND_CLOSE;
        end
    end

    // ids carried in the sent frame, zero when nothing is sent
    always_comb begin
        priority if (is_beacon) begin
            o_lid = nxt.local_id;
            o_pid = '0;
        end else if (unknown_close) begin
            o_lid = '0;
            o_pid = in_word.frame_sender_id;
        end else begin
            o_lid = nxt.local_id;
            o_pid = nxt.peer_id;
        end
    end

    assign o_rsn = unknown_close ? RSN_MISMATCH : nxt.close_reason;
    assign o_ls  = state_code(nxt.ls);

    always_comb begin
        res0.send_kind      = send;
        res0.send_local_id  = (send != SEND_NONE) ? o_lid : '0;
        res0.send_peer_id   = (send != SEND_NONE) ? o_pid : '0;
        res0.timer_action   = tact;
        res0.timer_value_ms = (tact == TM_START) ? tval : '0;
        res0.link_state     = o_ls;
        res0.peer_present   = nxt.present;
        res0.close_reason   = o_rsn;
        res0.last           = !two;

        res1.send_kind      = SEND_CONFIRM;
        res1.send_local_id  = nxt.local_id;
        res1.send_peer_id   = nxt.peer_id;
        res1.timer_action   = TM_LEAVE;
        res1.timer_value_ms = '0;
        res1.link_state     = o_ls;
        res1.peer_present   = nxt.present;
        res1.close_reason   = nxt.close_reason;
        res1.last           = 1'b1;
    end

endmodule
`default_nettype wire

// ----- src/mplf_out_fifo.sv -----
// Small result queue that takes one or two words per push.
`default_nettype none
module mplf_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push0,
    input  logic                push1,
    input  mplf_pkg::out_word_t din0,
    input  mplf_pkg::out_word_t din1,
    output logic                room2,
    output logic                m_valid,
    input  logic                m_ready,
    output mplf_pkg::out_word_t m_data
);
    import mplf_pkg::*;

    out_word_t               mem_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OBUF_PTR_W-1:0]   wr_ptr_p1;
    logic                    pop;

    assign pop       = m_valid && m_ready;
    assign m_valid   = cnt_reg != '0;
    assign m_data    = mem_reg[rd_ptr_reg];
    assign room2     = cnt_reg <= OBUF_CNT_W'(OBUF_DEPTH - 2);
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push0 && push1) wr_ptr_next = wr_ptr_reg + 2'(2);
        else if (push0)     wr_ptr_next = wr_ptr_p1;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OBUF_CNT_W'(push0) + OBUF_CNT_W'(push1)
                      - OBUF_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) mem_reg[wr_ptr_reg] <= din0;
        if (push1) mem_reg[wr_ptr_p1]  <= din1;
    end

endmodule
`default_nettype wire

// ----- src/mesh_peer_link_fsm.sv -----
// Top level of the per-neighbor mesh peering link state machine.
//
//   channel | ports                      | handshake    | word
//   --------+----------------------------+--------------+-----------------
//   input   | s_valid s_ready s_data     | valid/ready  | in_word_t
//   result  | m_valid m_ready m_data     | valid/ready  | out_word_t
//   config  | cfg_we cfg_index cfg_wdata | write enable | 16-bit data
//
// One input word per cycle while each word gives one result and m_ready stays high.
// An accepted word sits in the input register; classify/transition then updates the
// link state and pushes one or two result words into a 4-deep queue whose head is
// m_data. A word leaves the input register only with room for two in the queue; a
// stalled m side fills the queue and drops s_ready. Sync reset restores link, queue
// and config defaults.
`default_nettype none
module mesh_peer_link_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mplf_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mplf_pkg::out_word_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);
    import mplf_pkg::*;

    // configuration registers
    cfg_t      cfg_reg;

    // input register
    logic      in_valid_reg;
    in_word_t  in_data_reg;

    // per-peer link state
    link_t     link_reg;
    link_t     link_next;

    out_word_t res0;
    out_word_t res1;
    logic      two;
    logic      room2;
    logic      fire;

    // process the held word when the queue can take a pair
    assign fire    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_peer_links     <= MAX_LINKS_RST;
            cfg_reg.retry_timeout_ms   <= TIMEOUT_RST;
            cfg_reg.confirm_timeout_ms <= TIMEOUT_RST;
            cfg_reg.holding_timeout_ms <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_LINKS: cfg_reg.max_peer_links     <= cfg_wdata[7:0];
                REG_RETRY:     cfg_reg.retry_timeout_ms   <= cfg_wdata;
                REG_CONFIRM:   cfg_reg.confirm_timeout_ms <= cfg_wdata;
                REG_HOLDING:   cfg_reg.holding_timeout_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_data_reg <= s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.present      <= 1'b0;
            link_reg.ls           <= ST_LISTEN;
            link_reg.local_id     <= '0;
            link_reg.peer_id      <= '0;
            link_reg.close_reason <= RSN_NONE;
        end else if (fire) begin
            link_reg <= link_next;
        end
    end

    mplf_core u_core (
        .in_word (in_data_reg),
        .cfg     (cfg_reg),
        .cur     (link_reg),
        .nxt     (link_next),
        .res0    (res0),
        .res1    (res1),
        .two     (two)
    );

    // second word of a pair is the follow-up confirm
    mplf_out_fifo u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push0   (fire),
        .push1   (fire && two),
        .din0    (res0),
        .din1    (res1),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- src/mplf_checker.sv -----
// Port-level checks for the mesh peer link state machine, bound to the top.
`default_nettype none
`include "assert_macros.svh"
module mplf_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mplf_pkg::out_word_t m_data
);
    import mplf_pkg::*;

    `ASSERT_NEXT(a_m_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data),
        "result word changed while stalled")
    `ASSERT_HOLDS(a_tval_zero, aclk, aresetn,
        m_valid && m_data.timer_action != TM_START, m_data.timer_value_ms == '0,
        "timer value without timer start")
    `ASSERT_HOLDS(a_ids_zero, aclk, aresetn,
        m_valid && m_data.send_kind == SEND_NONE,
        m_data.send_local_id == '0 && m_data.send_peer_id == '0,
        "ids present with nothing sent")
    `ASSERT_HOLDS(a_pair_head, aclk, aresetn,
        m_valid && !m_data.last,
        m_data.send_kind == SEND_OPEN && m_data.link_state == LS_OPN_RCVD,
        "first of a pair is not an open in open received")
    `ASSERT_NEXT(a_pair_tail, aclk, aresetn,
        m_valid && m_ready && !m_data.last,
        m_valid && m_data.last && m_data.send_kind == SEND_CONFIRM,
        "pair not followed by its confirm")

endmodule

bind mesh_peer_link_fsm mplf_checker u_mplf_checker (.*);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the mesh peer link state machine.
`timescale 1ns / 1ps

module tb;
    import mplf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_OFF_CYCLES = 300;

    // Clock and synchronous active-low reset.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // All block inputs start at known values.
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    mesh_peer_link_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted configuration, mirrors what has been written to the block.
    logic [7:0]  cfg_max_links  = MAX_LINKS_RST;
    logic [15:0] cfg_retry_ms   = TIMEOUT_RST;
    logic [15:0] cfg_confirm_ms = TIMEOUT_RST;
    logic [15:0] cfg_holding_ms = TIMEOUT_RST;

    // Predicted per-peer link state.
    logic        lk_present  = 1'b0;
    logic [2:0]  lk_state    = LS_LISTEN;
    logic [15:0] lk_local_id = '0;
    logic [15:0] lk_peer_id  = '0;
    logic [1:0]  lk_reason   = RSN_NONE;

    // Result words the block still owes, oldest first.
    out_word_t link_results_q[$];

    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int cycle_count = 0;

    // Shared idling controls: no_idle gives stretches with no gaps on either side,
    // sink_hold asks the receiver for one long hold-off.
    bit no_idle = 1'b0;
    int sink_hold = 0;

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Link predictor
    // ------------------------------------------------------------------
    function automatic void clear_link();
        lk_state    = LS_LISTEN;
        lk_reason   = RSN_NONE;
        lk_peer_id  = '0;
        lk_local_id = '0;
    endfunction

    // Ids are zeroed when nothing is sent, the timer value unless starting.
    function automatic void push_result(logic [1:0] kind, logic [15:0] lid, logic [15:0] pid,
                                        logic [1:0] tact, logic [15:0] tval,
                                        logic [1:0] reason, logic is_last);
        out_word_t r;
        r.send_kind      = kind;
        r.send_local_id  = (kind != SEND_NONE) ? lid : 16'h0;
        r.send_peer_id   = (kind != SEND_NONE) ? pid : 16'h0;
        r.timer_action   = tact;
        r.timer_value_ms = (tact == TM_START) ? tval : 16'h0;
        r.link_state     = lk_state;
        r.peer_present   = lk_present;
        r.close_reason   = reason;
        r.last           = is_last;
        link_results_q.push_back(r);
    endfunction

    function automatic void advance_peer_link(in_word_t w);
        event_t      ev;
        logic [1:0]  snd;
        logic [1:0]  tact;
        logic [15:0] tval;
        logic        two;
        logic        prof_ok;
        logic        is_free;
        logic        reject;
        logic        to_hold;
        ev      = EV_NONE;
        snd     = SEND_NONE;
        tact    = TM_LEAVE;
        tval    = '0;
        two     = 1'b0;
        to_hold = 1'b0;
        is_free = (w.links_in_use < cfg_max_links);

        // Beacon: creates the entry and kicks off an open from listen.
        if (w.command == CMD_BEACON) begin
            lk_present = 1'b1;
            if (lk_state == LS_LISTEN) begin
                lk_local_id = w.fresh_local_id;
                lk_state    = LS_OPN_SNT;
                push_result(SEND_OPEN, lk_local_id, 16'h0, TM_START, cfg_retry_ms,
                            lk_reason, 1'b1);
            end else begin
                push_result(SEND_NONE, 16'h0, 16'h0, TM_LEAVE, 16'h0, lk_reason, 1'b1);
            end
            return;
        end

        if (w.dest_multicast || w.frame_kind == FK_OTHER) begin
            push_result(SEND_NONE, 16'h0, 16'h0, TM_LEAVE, 16'h0, lk_reason, 1'b1);
            return;
        end

        // Close frames never fail the profile check.
        prof_ok = (w.frame_kind == FK_CLOSE) || w.profile_match;

        if (!lk_present) begin
            // Unknown peer: mismatch is answered with a close, state untouched.
            if (!prof_ok) begin
                push_result(SEND_CLOSE, 16'h0, w.frame_sender_id, TM_LEAVE, 16'h0,
                            RSN_MISMATCH, 1'b1);
                return;
            end
            if (w.frame_kind == FK_OPEN && is_free) begin
                lk_present = 1'b1;
                clear_link();
                ev = EV_OPN_ACPT;
            end
        end else begin
            case (w.frame_kind)
                FK_OPEN: begin
                    if (!prof_ok)
                        ev = EV_OPN_RJCT;
                    else if (!is_free ||
                             (lk_peer_id != 16'h0 && lk_peer_id != w.frame_sender_id))
                        ev = EV_OPN_IGNR;
                    else
                        ev = EV_OPN_ACPT;
                end
                FK_CONFIRM: begin
                    if (!prof_ok)
                        ev = EV_CNF_RJCT;
                    else if (!is_free || lk_local_id != w.frame_receiver_id ||
                             (lk_peer_id != 16'h0 && lk_peer_id != w.frame_sender_id))
                        ev = EV_CNF_IGNR;
                    else
                        ev = EV_CNF_ACPT;
                end
                default: begin
                    // Close id check applies only outside estab.
                    if (lk_state == LS_ESTAB)
                        ev = EV_CLS_ACPT;
                    else if (lk_peer_id != w.frame_sender_id)
                        ev = EV_CLS_IGNR;
                    else if (lk_local_id != 16'h0 && lk_local_id != w.frame_receiver_id)
                        ev = EV_CLS_IGNR;
                    else
                        ev = EV_CLS_ACPT;
                end
            endcase
        end

        if (ev == EV_OPN_ACPT) lk_peer_id = w.frame_sender_id;
        if (ev == EV_CNF_ACPT && lk_peer_id == 16'h0) lk_peer_id = w.frame_sender_id;

        reject = (ev == EV_OPN_RJCT || ev == EV_CNF_RJCT);
        case (lk_state)
            LS_LISTEN: begin
                if (ev == EV_CLS_ACPT) begin
                    clear_link();
                end else if (ev == EV_OPN_ACPT) begin
                    lk_state    = LS_OPN_RCVD;
                    lk_local_id = w.fresh_local_id;
                    tact        = TM_START;
                    tval        = cfg_retry_ms;
                    snd         = SEND_OPEN;
                    two         = 1'b1;
                end
            end
            LS_OPN_SNT: begin
                if (reject || ev == EV_CLS_ACPT) begin
                    to_hold = 1'b1;
                end else if (ev == EV_OPN_ACPT) begin
                    lk_state = LS_OPN_RCVD;
                    snd      = SEND_CONFIRM;
                end else if (ev == EV_CNF_ACPT) begin
                    lk_state = LS_CNF_RCVD;
                    tact     = TM_START;
                    tval     = cfg_confirm_ms;
                end
            end
            LS_OPN_RCVD: begin
                if (reject || ev == EV_CLS_ACPT) begin
                    to_hold = 1'b1;
                end else if (ev == EV_OPN_ACPT) begin
                    snd = SEND_CONFIRM;
                end else if (ev == EV_CNF_ACPT) begin
                    tact     = TM_STOP;
                    lk_state = LS_ESTAB;
                end
            end
            LS_CNF_RCVD: begin
                if (reject || ev == EV_CLS_ACPT) begin
                    to_hold = 1'b1;
                end else if (ev == EV_OPN_ACPT) begin
                    tact     = TM_STOP;
                    lk_state = LS_ESTAB;
                    snd      = SEND_CONFIRM;
                end
            end
            LS_ESTAB: begin
                if (ev == EV_CLS_ACPT) to_hold = 1'b1;
                else if (ev == EV_OPN_ACPT) snd = SEND_CONFIRM;
            end
            LS_HOLDING: begin
                if (ev == EV_CLS_ACPT) begin
                    tact = TM_STOP;
                    clear_link();
                end else if (ev == EV_OPN_ACPT || ev == EV_CNF_ACPT || reject) begin
                    snd = SEND_CLOSE;
                end
            end
            default: ;
        endcase

        if (to_hold) begin
            lk_state  = LS_HOLDING;
            lk_reason = (ev == EV_CLS_ACPT) ? RSN_CLOSE : RSN_MISMATCH;
            tact      = TM_START;
            tval      = cfg_holding_ms;
            snd       = SEND_CLOSE;
        end

        // New link from listen answers with an open and then a confirm.
        if (two) begin
            push_result(snd, lk_local_id, lk_peer_id, tact, tval, lk_reason, 1'b0);
            push_result(SEND_CONFIRM, lk_local_id, lk_peer_id, TM_LEAVE, 16'h0,
                        lk_reason, 1'b1);
        end else begin
            push_result(snd, lk_local_id, lk_peer_id, tact, tval, lk_reason, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Called at a clock edge; returns at the edge where the word is taken.
    task automatic send_word(in_word_t w);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        advance_peer_link(w);
        words_sent++;
    endtask

    // Stop offering and wait for every owed result, plus pipeline slack.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (link_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_MAX_LINKS: cfg_max_links  = val[7:0];
            REG_RETRY:     cfg_retry_ms   = val;
            REG_CONFIRM:   cfg_confirm_ms = val;
            default:       cfg_holding_ms = val;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic apply_settings(logic [7:0] max_links, logic [15:0] retry_ms,
                                  logic [15:0] confirm_ms, logic [15:0] holding_ms);
        drain_results();
        // Upper byte of the link limit write is don't-care; toggle it anyway.
        cfg_write(REG_MAX_LINKS, {8'($urandom), max_links});
        cfg_write(REG_RETRY, retry_ms);
        cfg_write(REG_CONFIRM, confirm_ms);
        cfg_write(REG_HOLDING, holding_ms);
        settings_applied++;
    endtask

    function automatic in_word_t mk_word(logic cmd, logic [1:0] kind, logic mcast,
                                         logic [15:0] sid, logic [15:0] rid, logic prof,
                                         logic [7:0] inuse, logic [15:0] fresh);
        in_word_t w;
        w.command           = cmd;
        w.frame_kind        = kind;
        w.dest_multicast    = mcast;
        w.frame_sender_id   = sid;
        w.frame_receiver_id = rid;
        w.profile_match     = prof;
        w.links_in_use      = inuse;
        w.fresh_local_id    = fresh;
        return w;
    endfunction

    // Mostly well-formed peering traffic steered by the predicted link ids,
    // the rest plain noise over every field.
    function automatic in_word_t pick_word();
        in_word_t w;
        w.command           = 1'($urandom_range(0, 1));
        w.frame_kind        = 2'($urandom_range(0, 3));
        w.dest_multicast    = 1'($urandom_range(0, 1));
        w.frame_sender_id   = 16'($urandom);
        w.frame_receiver_id = 16'($urandom);
        w.profile_match     = 1'($urandom_range(0, 1));
        w.links_in_use      = 8'($urandom);
        w.fresh_local_id    = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            w.command        = ($urandom_range(0, 7) == 0) ? CMD_BEACON : CMD_FRAME;
            w.frame_kind     = 2'($urandom_range(0, 2));
            w.dest_multicast = ($urandom_range(0, 31) == 0);
            w.profile_match  = ($urandom_range(0, 9) != 0);
            if (lk_peer_id != 16'h0 && $urandom_range(0, 9) != 0)
                w.frame_sender_id = lk_peer_id;
            if ($urandom_range(0, 9) != 0)
                w.frame_receiver_id = lk_local_id;
            if (cfg_max_links != 8'h0 && $urandom_range(0, 9) != 0)
                w.links_in_use = 8'($urandom_range(0, cfg_max_links - 1));
        end
        return w;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            no_idle = ((i / 40) % 4 == 3);
            send_word(pick_word());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Walks the handshake through every state at reset settings, starting
    // with the unknown-peer cases, which are only reachable before any entry.
    task automatic test_directed_flows();
        // unknown peer
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b1, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OTHER,   1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h1234, 16'h0000, 1'b1, 8'd99, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h1234, 16'h0000, 1'b0, 8'd0, 16'h0));
        // open from peer: entry created, open + confirm sent
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h1234, 16'h0000, 1'b1, 8'd98, 16'hABCD));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h4321, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h1234, 16'hABCE, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h1234, 16'hABCD, 1'b1, 8'd0, 16'h0));
        // established
        send_word(mk_word(CMD_BEACON, FK_OPEN,   1'b0, 16'h0000, 16'h0000, 1'b0, 8'd0, 16'h5555));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h0000, 16'h0000, 1'b0, 8'd255, 16'h0));
        // holding: opens and rejects answered with close, id-checked close
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h1234, 16'hABCD, 1'b0, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h1235, 16'hABCD, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h1234, 16'hABCD, 1'b1, 8'd0, 16'h0));
        // beacon -> open sent -> confirm rcvd -> estab -> holding -> listen
        send_word(mk_word(CMD_BEACON, FK_CLOSE,  1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'd255, 16'hFFFF));
        send_word(mk_word(CMD_FRAME, FK_CONFIRM, 1'b0, 16'h0001, 16'hFFFF, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'h0001, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h0001, 16'hFFFF, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'h0001, 16'hFFFF, 1'b1, 8'd0, 16'h0));
        // open sent with zero local id, an accepted open, then a profile mismatch into holding
        send_word(mk_word(CMD_BEACON, FK_OPEN,   1'b0, 16'h0000, 16'h0000, 1'b0, 8'd0, 16'h0000));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'hFFFF, 16'h0000, 1'b1, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_OPEN,    1'b0, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 16'h0));
        send_word(mk_word(CMD_FRAME, FK_CLOSE,   1'b0, 16'hFFFF, 16'h1111, 1'b1, 8'd0, 16'h0));
    endtask

    task automatic test_register_extremes();
        apply_settings(8'd0, 16'h0000, 16'h0000, 16'h0000);
        run_random(40);
        apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(40);
        apply_settings(8'd1, 16'h0001, 16'h0002, 16'h0003);
        run_random(40);
        apply_settings(MAX_LINKS_RST, TIMEOUT_RST, TIMEOUT_RST, TIMEOUT_RST);
        run_random(40);
    endtask

    // Receiver parks for a long stretch while words keep coming, so the
    // result queue fills and s_ready must drop; then the sender waits out
    // every result before moving on.
    task automatic test_result_backpressure();
        sink_hold = HOLD_OFF_CYCLES;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) send_word(pick_word());
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        apply_settings(8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom),
                       16'($urandom));
        run_random(450);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                stall = sink_hold;
                sink_hold = 0;
            end else begin
                stall = idle_draw();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (link_results_q.size() == 0) begin
                $display("%0t: result word %h with none expected", $time, m_data);
                mismatches++;
            end else begin
                want = link_results_q.pop_front();
                check_field("send_kind", 16'(want.send_kind), 16'(m_data.send_kind));
                check_field("send_local_id", want.send_local_id, m_data.send_local_id);
                check_field("send_peer_id", want.send_peer_id, m_data.send_peer_id);
                check_field("timer_action", 16'(want.timer_action),
                            16'(m_data.timer_action));
                check_field("timer_value_ms", want.timer_value_ms, m_data.timer_value_ms);
                check_field("link_state", 16'(want.link_state), 16'(m_data.link_state));
                check_field("peer_present", 16'(want.peer_present),
                            16'(m_data.peer_present));
                check_field("close_reason", 16'(want.close_reason),
                            16'(m_data.close_reason));
                check_field("last", 16'(want.last), 16'(m_data.last));
                results_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_flows();
        test_register_extremes();
        test_result_backpressure();
        test_random_traffic();
        drain_results();

        if (link_results_q.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, link_results_q.size());
            mismatches++;
        end
        $display("covered %0d input words and %0d result words over %0d register settings",
                 words_sent, results_checked, settings_applied);
        $display("directed peering flows, register extremes, long result stall, random mix");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
